### rtl/core/wpfam_pkg.sv
package wpfam_pkg;

    // Default build of the value path
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 48;

    // Fixed field widths
    localparam int WORD_W      = 16;
    localparam int LIMIT_W     = 48;
    localparam int BAND_W      = 47;
    localparam int SEVSET_W    = 8;
    localparam int SEV_W       = 2;
    localparam int COND_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Float layout: 24-bit mantissa with hidden bit, bias plus mantissa shift
    localparam int MANT_W          = 24;
    localparam int EXP_W           = 8;
    localparam int EXP_BIAS_SHIFT  = 150;
    localparam int SIGN_BIT        = 15;
    localparam int EXP_LSB         = 7;
    localparam int MANT_HI_W       = 7;

    // Packed severities in severity_set
    localparam int SEV_HIHI_LSB = 6;
    localparam int SEV_LOLO_LSB = 4;
    localparam int SEV_HIGH_LSB = 2;
    localparam int SEV_LOW_LSB  = 0;

    // Depth of the queue between classification and evaluation
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [COND_W-1:0] {
        COND_NONE = 3'd0,
        COND_HIHI = 3'd1,
        COND_LOLO = 3'd2,
        COND_HIGH = 3'd3,
        COND_LOW  = 3'd4
    } cond_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HIHI_LIMIT       = 3'd0,
        REG_HIGH_LIMIT       = 3'd1,
        REG_LOW_LIMIT        = 3'd2,
        REG_LOLO_LIMIT       = 3'd3,
        REG_HYSTERESIS       = 3'd4,
        REG_VALUE_DEADBAND   = 3'd5,
        REG_ARCHIVE_DEADBAND = 3'd6,
        REG_SEVERITY_SET     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [LIMIT_W-1:0]  hihi_limit;
        logic signed [LIMIT_W-1:0]  high_limit;
        logic signed [LIMIT_W-1:0]  low_limit;
        logic signed [LIMIT_W-1:0]  lolo_limit;
        logic        [BAND_W-1:0]   hysteresis;
        logic        [BAND_W-1:0]   value_deadband;
        logic        [BAND_W-1:0]   archive_deadband;
        logic        [SEVSET_W-1:0] severity_set;
    } cfg_t;

    // hit: value is at or past the limit; near: value is within hysteresis of it
    typedef struct packed {
        logic hihi_hit;
        logic hihi_near;
        logic lolo_hit;
        logic lolo_near;
        logic high_hit;
        logic high_near;
        logic low_hit;
        logic low_near;
    } limit_flags_t;

endpackage

### rtl/core/wpfam_front.sv
module wpfam_front #(
    parameter int FRACTION_BITS = wpfam_pkg::FRACTION_BITS_DEF,
    parameter int VALUE_WIDTH   = wpfam_pkg::VALUE_WIDTH_DEF,
    parameter int ENTRY_W       = VALUE_WIDTH + 2 * wpfam_pkg::WORD_W
                                  + $bits(wpfam_pkg::limit_flags_t)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpfam_pkg::cfg_t                 cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wpfam_pkg::WORD_W-1:0]    word_high,
    input  logic [wpfam_pkg::WORD_W-1:0]    word_low,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [ENTRY_W-1:0]              push_data
);

    localparam int LVL_W = (VALUE_WIDTH > wpfam_pkg::LIMIT_W) ? VALUE_WIDTH
                                                              : wpfam_pkg::LIMIT_W;
    localparam logic signed [9:0] SHIFT_OFS =
        10'(FRACTION_BITS - wpfam_pkg::EXP_BIAS_SHIFT);
    // at or above this shift the mantissa's top bit falls outside the value word
    localparam logic signed [9:0] SAT_SHIFT =
        10'(VALUE_WIDTH - wpfam_pkg::MANT_W + 1);
    localparam logic [VALUE_WIDTH-1:0] CAP = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

    function automatic logic [LVL_W:0] abs_diff(input logic signed [LVL_W-1:0] a,
                                                input logic signed [LVL_W-1:0] b);
        logic signed [LVL_W:0] d;
        d = (LVL_W+1)'(a) - (LVL_W+1)'(b);
        return d[LVL_W] ? (LVL_W+1)'(-d) : (LVL_W+1)'(d);
    endfunction

    // stage 1: float to fixed point
    logic                                s1_valid_reg, s1_valid_next;
    logic signed [VALUE_WIDTH-1:0]       s1_value_reg, s1_value_next;
    logic [wpfam_pkg::WORD_W-1:0]        s1_high_reg, s1_low_reg;

    // stage 2: limit classification
    logic                                s2_valid_reg, s2_valid_next;
    logic signed [VALUE_WIDTH-1:0]       s2_value_reg;
    logic [wpfam_pkg::WORD_W-1:0]        s2_high_reg, s2_low_reg;
    wpfam_pkg::limit_flags_t             s2_flags_reg, s2_flags_next;

    logic s1_free, s2_free, s1_move, in_take;

    assign s2_free  = !s2_valid_reg || push_ready;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign in_take  = in_valid && s1_free;

    assign s1_valid_next = in_take || (s1_valid_reg && !s2_free);
    assign s2_valid_next = s1_move || (s2_valid_reg && !push_ready);

    // conversion
    logic                          sgn;
    logic [wpfam_pkg::EXP_W-1:0]   expo;
    logic [wpfam_pkg::MANT_W-1:0]  mant;
    logic signed [9:0]             shift_amt;
    logic [9:0]                    shl, shr;
    logic                          shift_neg, too_big;
    logic [VALUE_WIDTH-1:0]        mant_w, mag, mag_lim, mag_sat;

    always_comb
    begin
        sgn       = word_high[wpfam_pkg::SIGN_BIT];
        expo      = word_high[wpfam_pkg::EXP_LSB +: wpfam_pkg::EXP_W];
        mant      = {1'b1, word_high[wpfam_pkg::MANT_HI_W-1:0], word_low};
        shift_amt = $signed({2'b00, expo}) + SHIFT_OFS;
        shift_neg = shift_amt[9];
        shl       = shift_amt;
        shr       = -shift_amt;
        mant_w    = VALUE_WIDTH'(mant);
        mag       = shift_neg ? (mant_w >> shr) : (mant_w << shl);
        too_big   = !shift_neg && (shift_amt >= SAT_SHIFT);
        mag_lim   = sgn ? CAP : (CAP - VALUE_WIDTH'(1));
        mag_sat   = (too_big || (mag > mag_lim)) ? mag_lim : mag;
        s1_value_next = sgn ? $signed(-mag_sat) : $signed(mag_sat);
    end

    // classification against the configured limits
    logic signed [LVL_W-1:0] v_ext, hihi_x, high_x, low_x, lolo_x;
    logic        [LVL_W:0]   hyst_x;

    always_comb
    begin
        v_ext  = LVL_W'(s1_value_reg);
        hihi_x = LVL_W'(cfg.hihi_limit);
        high_x = LVL_W'(cfg.high_limit);
        low_x  = LVL_W'(cfg.low_limit);
        lolo_x = LVL_W'(cfg.lolo_limit);
        hyst_x = (LVL_W+1)'(cfg.hysteresis);
        s2_flags_next.hihi_hit  = v_ext >= hihi_x;
        s2_flags_next.hihi_near = abs_diff(hihi_x, v_ext) <= hyst_x;
        s2_flags_next.lolo_hit  = v_ext <= lolo_x;
        s2_flags_next.lolo_near = abs_diff(v_ext, lolo_x) <= hyst_x;
        s2_flags_next.high_hit  = v_ext >= high_x;
        s2_flags_next.high_near = abs_diff(high_x, v_ext) <= hyst_x;
        s2_flags_next.low_hit   = v_ext <= low_x;
        s2_flags_next.low_near  = abs_diff(v_ext, low_x) <= hyst_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_value_reg <= s1_value_next;
            s1_high_reg  <= word_high;
            s1_low_reg   <= word_low;
        end
        if (s1_move)
        begin
            s2_value_reg <= s1_value_reg;
            s2_high_reg  <= s1_high_reg;
            s2_low_reg   <= s1_low_reg;
            s2_flags_reg <= s2_flags_next;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_data  = {s2_value_reg, s2_high_reg, s2_low_reg, s2_flags_reg};

endmodule

### rtl/core/wpfam_queue.sv
module wpfam_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wpfam_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/core/wpfam_back.sv
module wpfam_back #(
    parameter int VALUE_WIDTH = wpfam_pkg::VALUE_WIDTH_DEF,
    parameter int ENTRY_W     = VALUE_WIDTH + 2 * wpfam_pkg::WORD_W
                                + $bits(wpfam_pkg::limit_flags_t)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpfam_pkg::cfg_t                 cfg,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [ENTRY_W-1:0]              pop_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [VALUE_WIDTH-1:0]   value,
    output logic [wpfam_pkg::COND_W-1:0]    alarm_condition,
    output logic [wpfam_pkg::SEV_W-1:0]     alarm_severity,
    output logic                            alarm_event,
    output logic                            value_event,
    output logic                            archive_event,
    output logic                            high_word_event,
    output logic                            low_word_event
);

    localparam int LVL_W = (VALUE_WIDTH > wpfam_pkg::LIMIT_W) ? VALUE_WIDTH
                                                              : wpfam_pkg::LIMIT_W;

    function automatic logic [LVL_W:0] abs_diff(input logic signed [LVL_W-1:0] a,
                                                input logic signed [LVL_W-1:0] b);
        logic signed [LVL_W:0] d;
        d = (LVL_W+1)'(a) - (LVL_W+1)'(b);
        return d[LVL_W] ? (LVL_W+1)'(-d) : (LVL_W+1)'(d);
    endfunction

    // transaction popped from the queue
    logic signed [VALUE_WIDTH-1:0]  e_value;
    logic [wpfam_pkg::WORD_W-1:0]   e_high, e_low;
    wpfam_pkg::limit_flags_t        e_flags;

    assign {e_value, e_high, e_low, e_flags} = pop_data;

    // running state
    logic signed [LVL_W-1:0]       lalm_reg, lalm_next;
    logic signed [LVL_W-1:0]       lmon_reg, larc_reg;
    logic [wpfam_pkg::WORD_W-1:0]  prev_high_reg, prev_low_reg;
    wpfam_pkg::cond_t              prev_cond_reg, cond_next;
    logic [wpfam_pkg::SEV_W-1:0]   prev_sev_reg, sev_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic                          aev_reg, vev_reg, arev_reg, hev_reg, lev_reg;
    logic                          aev_next, vev_next, arev_next, hev_next, lev_next;

    logic load;

    assign pop_ready      = !out_valid_reg || !out_stall;
    assign load           = pop_valid && pop_ready;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    logic signed [LVL_W-1:0]     v_ext, hihi_x, high_x, low_x, lolo_x;
    logic [wpfam_pkg::SEV_W-1:0] sv_hihi, sv_high, sv_low, sv_lolo;
    logic                        fire_hihi, fire_lolo, fire_high, fire_low;

    always_comb
    begin
        v_ext   = LVL_W'(e_value);
        hihi_x  = LVL_W'(cfg.hihi_limit);
        high_x  = LVL_W'(cfg.high_limit);
        low_x   = LVL_W'(cfg.low_limit);
        lolo_x  = LVL_W'(cfg.lolo_limit);
        sv_hihi = cfg.severity_set[wpfam_pkg::SEV_HIHI_LSB +: wpfam_pkg::SEV_W];
        sv_lolo = cfg.severity_set[wpfam_pkg::SEV_LOLO_LSB +: wpfam_pkg::SEV_W];
        sv_high = cfg.severity_set[wpfam_pkg::SEV_HIGH_LSB +: wpfam_pkg::SEV_W];
        sv_low  = cfg.severity_set[wpfam_pkg::SEV_LOW_LSB +: wpfam_pkg::SEV_W];

        // hysteresis applies only to the level that was last active
        fire_hihi = (sv_hihi != '0) &&
                    (e_flags.hihi_hit || ((lalm_reg == hihi_x) && e_flags.hihi_near));
        fire_lolo = (sv_lolo != '0) &&
                    (e_flags.lolo_hit || ((lalm_reg == lolo_x) && e_flags.lolo_near));
        fire_high = (sv_high != '0) &&
                    (e_flags.high_hit || ((lalm_reg == high_x) && e_flags.high_near));
        fire_low  = (sv_low != '0) &&
                    (e_flags.low_hit || ((lalm_reg == low_x) && e_flags.low_near));

        priority if (fire_hihi)
        begin
            cond_next = wpfam_pkg::COND_HIHI;
            sev_next  = sv_hihi;
            lalm_next = hihi_x;
        end
        else if (fire_lolo)
        begin
            cond_next = wpfam_pkg::COND_LOLO;
            sev_next  = sv_lolo;
            lalm_next = lolo_x;
        end
        else if (fire_high)
        begin
            cond_next = wpfam_pkg::COND_HIGH;
            sev_next  = sv_high;
            lalm_next = high_x;
        end
        else if (fire_low)
        begin
            cond_next = wpfam_pkg::COND_LOW;
            sev_next  = sv_low;
            lalm_next = low_x;
        end
        else
        begin
            cond_next = wpfam_pkg::COND_NONE;
            sev_next  = '0;
            lalm_next = v_ext;
        end

        aev_next  = (cond_next != prev_cond_reg) || (sev_next != prev_sev_reg);
        vev_next  = abs_diff(lmon_reg, v_ext) > (LVL_W+1)'(cfg.value_deadband);
        arev_next = abs_diff(larc_reg, v_ext) > (LVL_W+1)'(cfg.archive_deadband);
        hev_next  = aev_next || (e_high != prev_high_reg);
        lev_next  = aev_next || (e_low != prev_low_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lalm_reg      <= '0;
            lmon_reg      <= '0;
            larc_reg      <= '0;
            prev_high_reg <= '0;
            prev_low_reg  <= '0;
            prev_cond_reg <= wpfam_pkg::COND_NONE;
            prev_sev_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                lalm_reg      <= lalm_next;
                prev_high_reg <= e_high;
                prev_low_reg  <= e_low;
                prev_cond_reg <= cond_next;
                prev_sev_reg  <= sev_next;
                if (vev_next)
                    lmon_reg <= v_ext;
                if (arev_next)
                    larc_reg <= v_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= e_value;
            aev_reg   <= aev_next;
            vev_reg   <= vev_next;
            arev_reg  <= arev_next;
            hev_reg   <= hev_next;
            lev_reg   <= lev_next;
        end
    end

    // condition and severity of the held result are the last stored ones
    assign out_valid       = out_valid_reg;
    assign value           = value_reg;
    assign alarm_condition = prev_cond_reg;
    assign alarm_severity  = prev_sev_reg;
    assign alarm_event     = aev_reg;
    assign value_event     = vev_reg;
    assign archive_event   = arev_reg;
    assign high_word_event = hev_reg;
    assign low_word_event  = lev_reg;

endmodule

### rtl/core/word_pair_float_alarm_monitor.sv
// Word-pair float alarm monitor.
// Input channel (in_valid/in_stall, word_high, word_low): one transaction is a
// 32-bit float split in two 16-bit words, hidden bit always set. Output channel
// (out_valid/out_stall): one result transaction per input, in order, carrying
// the saturated fixed-point value, alarm condition and severity, and events.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the limits,
// hysteresis, deadbands and severity set; cfg_ready is always high, and writes
// are meant to happen only while no transaction is in flight.
// Path: input acceptance to out_valid runs through convert, classify, queue
// and evaluate, each registered. Throughput: one transaction per cycle while
// out_stall is low; the back end updates its alarm/deadband state as it loads each.
// Reset clears the valid flags, queue pointers, configuration, the alarm history
// and the deadband references to zero. When out_stall is high the result holds;
// the back end stops, the queue fills, and only then does in_stall rise.
module word_pair_float_alarm_monitor #(
    parameter int FRACTION_BITS = wpfam_pkg::FRACTION_BITS_DEF,
    parameter int VALUE_WIDTH   = wpfam_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wpfam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wpfam_pkg::CFG_DATA_W-1:0]  cfg_data,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wpfam_pkg::WORD_W-1:0]      word_high,
    input  logic [wpfam_pkg::WORD_W-1:0]      word_low,

    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [VALUE_WIDTH-1:0]     value,
    output logic [wpfam_pkg::COND_W-1:0]      alarm_condition,
    output logic [wpfam_pkg::SEV_W-1:0]       alarm_severity,
    output logic                              alarm_event,
    output logic                              value_event,
    output logic                              archive_event,
    output logic                              high_word_event,
    output logic                              low_word_event
);

    // queue entry: value, both words, limit flags
    localparam int ENTRY_W = VALUE_WIDTH + 2 * wpfam_pkg::WORD_W
                             + $bits(wpfam_pkg::limit_flags_t);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    wpfam_pkg::cfg_t cfg_reg, cfg_next;
    logic            cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (wpfam_pkg::reg_index_t'(cfg_index))
                wpfam_pkg::REG_HIHI_LIMIT:
                    cfg_next.hihi_limit = cfg_data;
                wpfam_pkg::REG_HIGH_LIMIT:
                    cfg_next.high_limit = cfg_data;
                wpfam_pkg::REG_LOW_LIMIT:
                    cfg_next.low_limit = cfg_data;
                wpfam_pkg::REG_LOLO_LIMIT:
                    cfg_next.lolo_limit = cfg_data;
                wpfam_pkg::REG_HYSTERESIS:
                    cfg_next.hysteresis = cfg_data[wpfam_pkg::BAND_W-1:0];
                wpfam_pkg::REG_VALUE_DEADBAND:
                    cfg_next.value_deadband = cfg_data[wpfam_pkg::BAND_W-1:0];
                wpfam_pkg::REG_ARCHIVE_DEADBAND:
                    cfg_next.archive_deadband = cfg_data[wpfam_pkg::BAND_W-1:0];
                wpfam_pkg::REG_SEVERITY_SET:
                    cfg_next.severity_set = cfg_data[wpfam_pkg::SEVSET_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // ---------------------------------------------------------------------
    // Front end: float conversion and limit classification
    // ---------------------------------------------------------------------
    logic               push_valid, push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    wpfam_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word_high  (word_high),
        .word_low   (word_low),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // ---------------------------------------------------------------------
    // Decoupling queue
    // ---------------------------------------------------------------------
    wpfam_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (wpfam_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // ---------------------------------------------------------------------
    // Back end: alarm evaluation with hysteresis, deadbands, word events
    // ---------------------------------------------------------------------
    wpfam_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .value           (value),
        .alarm_condition (alarm_condition),
        .alarm_severity  (alarm_severity),
        .alarm_event     (alarm_event),
        .value_event     (value_event),
        .archive_event   (archive_event),
        .high_word_event (high_word_event),
        .low_word_event  (low_word_event)
    );

endmodule

### sim/wpfam_alarm_checker.sv
module wpfam_alarm_checker
    import wpfam_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [CFG_INDEX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [WORD_W-1:0]                   word_high,
    input  logic [WORD_W-1:0]                   word_low,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [VALUE_WIDTH_DEF-1:0]   value,
    input  logic [COND_W-1:0]                   alarm_condition,
    input  logic [SEV_W-1:0]                    alarm_severity,
    input  logic                                alarm_event,
    input  logic                                value_event,
    input  logic                                archive_event,
    input  logic                                high_word_event,
    input  logic                                low_word_event,

    output int                                  mismatch_count,
    output int                                  results_pending
);

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int FB = FRACTION_BITS_DEF;

    typedef struct packed {
        logic signed [VW-1:0] value;
        cond_t                cond;
        logic [SEV_W-1:0]     sev;
        logic                 alarm_ev;
        logic                 value_ev;
        logic                 archive_ev;
        logic                 high_word_ev;
        logic                 low_word_ev;
    } alarm_result_t;

    // mirrored registers and alarm/deadband history
    cfg_t                 limits_cfg;
    logic signed [VW-1:0] alarm_level;
    logic signed [VW-1:0] monitored_ref;
    logic signed [VW-1:0] archived_ref;
    logic [WORD_W-1:0]    prev_high_word;
    logic [WORD_W-1:0]    prev_low_word;
    cond_t                prev_cond;
    logic [SEV_W-1:0]     prev_sev;

    alarm_result_t        expected_results[$];
    alarm_result_t        oldest;
    int                   mismatches;

    // float pattern -> saturated fixed point, hidden bit always set, truncation toward zero
    function automatic logic signed [VW-1:0] word_pair_to_fixed(logic [WORD_W-1:0] hi,
                                                                logic [WORD_W-1:0] lo);
        logic [MANT_W-1:0] mant;
        logic [63:0]       mag;
        logic [63:0]       cap;
        int                shift;
        mant  = {1'b1, hi[MANT_HI_W-1:0], lo};
        shift = int'(hi[SIGN_BIT-1:EXP_LSB]) - EXP_BIAS_SHIFT + FB;
        cap   = hi[SIGN_BIT] ? (64'd1 << (VW-1)) : (64'd1 << (VW-1)) - 64'd1;
        if (shift >= 0)
            mag = (MANT_W - 1 + shift >= 64) ? cap : (64'(mant) << shift);
        else
            mag = (-shift >= MANT_W) ? 64'd0 : (64'(mant) >> (-shift));
        if (mag > cap)
            mag = cap;
        return hi[SIGN_BIT] ? VW'(-mag) : VW'(mag);
    endfunction

    function automatic longint band_distance(logic signed [VW-1:0] a, logic signed [VW-1:0] b);
        longint x;
        longint y;
        x = a;
        y = b;
        return (x >= y) ? x - y : y - x;
    endfunction

    function automatic alarm_result_t predict_alarm_result(logic [WORD_W-1:0] hi,
                                                           logic [WORD_W-1:0] lo);
        alarm_result_t        r;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] lim_hihi;
        logic signed [VW-1:0] lim_high;
        logic signed [VW-1:0] lim_low;
        logic signed [VW-1:0] lim_lolo;
        logic [SEV_W-1:0]     sev_hihi;
        logic [SEV_W-1:0]     sev_lolo;
        logic [SEV_W-1:0]     sev_high;
        logic [SEV_W-1:0]     sev_low;
        longint               hyst;
        v        = word_pair_to_fixed(hi, lo);
        lim_hihi = $signed(limits_cfg.hihi_limit);
        lim_high = $signed(limits_cfg.high_limit);
        lim_low  = $signed(limits_cfg.low_limit);
        lim_lolo = $signed(limits_cfg.lolo_limit);
        sev_hihi = limits_cfg.severity_set[SEV_HIHI_LSB +: SEV_W];
        sev_lolo = limits_cfg.severity_set[SEV_LOLO_LSB +: SEV_W];
        sev_high = limits_cfg.severity_set[SEV_HIGH_LSB +: SEV_W];
        sev_low  = limits_cfg.severity_set[SEV_LOW_LSB +: SEV_W];
        hyst     = longint'(limits_cfg.hysteresis);

        r.value = v;
        r.cond  = COND_NONE;
        r.sev   = '0;
        // priority hihi, lolo, high, low; a held level needs hysteresis margin to clear
        if (sev_hihi != 0 && (v >= lim_hihi ||
            (alarm_level == lim_hihi && band_distance(lim_hihi, v) <= hyst)))
        begin
            r.cond      = COND_HIHI;
            r.sev       = sev_hihi;
            alarm_level = lim_hihi;
        end
        else if (sev_lolo != 0 && (v <= lim_lolo ||
                 (alarm_level == lim_lolo && band_distance(v, lim_lolo) <= hyst)))
        begin
            r.cond      = COND_LOLO;
            r.sev       = sev_lolo;
            alarm_level = lim_lolo;
        end
        else if (sev_high != 0 && (v >= lim_high ||
                 (alarm_level == lim_high && band_distance(lim_high, v) <= hyst)))
        begin
            r.cond      = COND_HIGH;
            r.sev       = sev_high;
            alarm_level = lim_high;
        end
        else if (sev_low != 0 && (v <= lim_low ||
                 (alarm_level == lim_low && band_distance(v, lim_low) <= hyst)))
        begin
            r.cond      = COND_LOW;
            r.sev       = sev_low;
            alarm_level = lim_low;
        end
        else
        begin
            alarm_level = v;
        end

        r.alarm_ev   = (r.cond != prev_cond) || (r.sev != prev_sev);
        r.value_ev   = band_distance(monitored_ref, v) > longint'(limits_cfg.value_deadband);
        r.archive_ev = band_distance(archived_ref, v) > longint'(limits_cfg.archive_deadband);
        r.high_word_ev = r.alarm_ev || (hi != prev_high_word);
        r.low_word_ev  = r.alarm_ev || (lo != prev_low_word);

        prev_cond      = r.cond;
        prev_sev       = r.sev;
        prev_high_word = hi;
        prev_low_word  = lo;
        if (r.value_ev)
            monitored_ref = v;
        if (r.archive_ev)
            archived_ref = v;
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_cfg     = '0;
            alarm_level    = '0;
            monitored_ref  = '0;
            archived_ref   = '0;
            prev_high_word = '0;
            prev_low_word  = '0;
            prev_cond      = COND_NONE;
            prev_sev       = '0;
            mismatches     = 0;
            expected_results.delete();
            mismatch_count  <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_HIHI_LIMIT:       limits_cfg.hihi_limit       = cfg_data[LIMIT_W-1:0];
                    REG_HIGH_LIMIT:       limits_cfg.high_limit       = cfg_data[LIMIT_W-1:0];
                    REG_LOW_LIMIT:        limits_cfg.low_limit        = cfg_data[LIMIT_W-1:0];
                    REG_LOLO_LIMIT:       limits_cfg.lolo_limit       = cfg_data[LIMIT_W-1:0];
                    REG_HYSTERESIS:       limits_cfg.hysteresis       = cfg_data[BAND_W-1:0];
                    REG_VALUE_DEADBAND:   limits_cfg.value_deadband   = cfg_data[BAND_W-1:0];
                    REG_ARCHIVE_DEADBAND: limits_cfg.archive_deadband = cfg_data[BAND_W-1:0];
                    default:              limits_cfg.severity_set     = cfg_data[SEVSET_W-1:0];
                endcase
            end

            if (in_valid && !in_stall)
                expected_results.push_back(predict_alarm_result(word_high, word_low));

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("value", longint'(oldest.value), longint'(value));
                    check_field("alarm_condition", longint'(oldest.cond),
                                longint'(alarm_condition));
                    check_field("alarm_severity", longint'(oldest.sev), longint'(alarm_severity));
                    check_field("alarm_event", longint'(oldest.alarm_ev), longint'(alarm_event));
                    check_field("value_event", longint'(oldest.value_ev), longint'(value_event));
                    check_field("archive_event", longint'(oldest.archive_ev),
                                longint'(archive_event));
                    check_field("high_word_event", longint'(oldest.high_word_ev),
                                longint'(high_word_event));
                    check_field("low_word_event", longint'(oldest.low_word_ev),
                                longint'(low_word_event));
                end
            end

            mismatch_count  <= mismatches;
            results_pending <= expected_results.size();
        end
    end

endmodule

### sim/word_pair_float_alarm_monitor_test.sv
module word_pair_float_alarm_monitor_test;

    import wpfam_pkg::*;

    localparam int LIMIT_COUNT    = 4;
    localparam int CHUNK_COUNT    = 7;
    localparam int CHUNK_ITEMS    = 250;
    localparam int LIGHT_IDLE_PCT = 22;
    localparam int HEAVY_IDLE_PCT = 84;
    // idle margin after the pipeline drains, before touching registers
    localparam int SETTLE_CYCLES  = 8;
    localparam int RUN_LIMIT      = 400000;
    // exponent code at which the fixed-point value equals the 24-bit mantissa
    localparam int UNITY_EXP      = EXP_BIAS_SHIFT - FRACTION_BITS_DEF;

    typedef enum int {
        CFG_ORDERED,    // hihi > high > 0 > low > lolo, all checks enabled
        CFG_SHUFFLED,   // limits anywhere, any sign, random severities
        CFG_EXTREME,    // limits at the rails, max hysteresis, zero deadbands
        CFG_DISABLED    // every check off, deadbands wide open
    } setting_kind_t;

    // register setting used by each random chunk, in run order
    localparam setting_kind_t CHUNK_KIND [CHUNK_COUNT] = '{
        CFG_ORDERED, CFG_SHUFFLED, CFG_EXTREME, CFG_ORDERED,
        CFG_DISABLED, CFG_SHUFFLED, CFG_ORDERED
    };

    // Directed float patterns (high word first):
    //   zero and negative zero, both saturation rails, exponent 255 patterns,
    //   an exact integer, hihi entered / held by hysteresis / left for high,
    //   a plain in-range value, low and lolo entered and lolo held,
    //   a repeated transaction (no word events), a low-word-only change,
    //   the unit-shift exponent, truncation down to 0 and to +/-1,
    //   exactly the most negative value and one step past the positive rail.
    localparam logic [31:0] DIRECTED_FLOATS [24] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'h4B00_0000, 32'h4680_0000, 32'h467F_FFFF, 32'h4600_0000,
        32'h3F80_0000, 32'hC180_0000, 32'hC680_0000, 32'hC67F_FFFF,
        32'hC67F_FFFF, 32'hC67F_FFFE, 32'h4300_0001, 32'h3700_0000,
        32'h3780_0000, 32'hB780_0000, 32'hCF00_0000, 32'h4F00_0000,
        32'h4EFF_FFFF, 32'h7F80_0000, 32'h7FC0_0000, 32'hC100_0000
    };

    logic                                clk             = 1'b0;
    logic                                rst_n           = 1'b0;

    logic                                cfg_valid       = 1'b0;
    logic                                cfg_ready;
    logic [CFG_INDEX_W-1:0]              cfg_index       = '0;
    logic [CFG_DATA_W-1:0]               cfg_data        = '0;

    logic                                in_valid        = 1'b0;
    logic                                in_stall;
    logic [WORD_W-1:0]                   word_high       = '0;
    logic [WORD_W-1:0]                   word_low        = '0;

    logic                                out_valid;
    logic                                out_stall       = 1'b0;
    logic signed [VALUE_WIDTH_DEF-1:0]   value;
    logic [COND_W-1:0]                   alarm_condition;
    logic [SEV_W-1:0]                    alarm_severity;
    logic                                alarm_event;
    logic                                value_event;
    logic                                archive_event;
    logic                                high_word_event;
    logic                                low_word_event;

    int                                  mismatch_count;
    int                                  results_pending;

    // idle rates of each side, in percent of cycles
    int                                  send_idle_pct   = 0;
    int                                  recv_idle_pct   = 0;

    // register images written by program_registers, indexed by reg_index_t
    logic [CFG_DATA_W-1:0]               reg_data [1 << CFG_INDEX_W];

    // float patterns sitting exactly on the current limits; random items
    // cluster around one of them so alarms get entered, held and released
    logic [31:0]                         near_bits [LIMIT_COUNT];
    int                                  focus_slot      = 0;
    logic [31:0]                         prev_bits       = '0;

    word_pair_float_alarm_monitor i_dut (.*);

    wpfam_alarm_checker i_checker (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // receiver: random back-pressure on the result channel
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    function automatic logic [CFG_DATA_W-1:0] random_word48();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // Limit that is exactly representable as a float of the given exponent
    // range; its pattern is kept so items can be aimed right at it.
    function automatic logic [CFG_DATA_W-1:0] float_limit(int slot, int e_lo, int e_hi, bit neg);
        logic [7:0]  e;
        logic [22:0] frac;
        logic [63:0] mag;
        e    = 8'($urandom_range(e_hi, e_lo));
        frac = 23'($urandom);
        near_bits[slot] = {neg, e, frac};
        mag  = 64'({1'b1, frac}) << (int'(e) - UNITY_EXP);
        return neg ? CFG_DATA_W'(-mag) : CFG_DATA_W'(mag);
    endfunction

    task automatic make_config(setting_kind_t kind);
        case (kind)
            CFG_ORDERED:
            begin
                reg_data[REG_HIHI_LIMIT] = float_limit(0, 146, 152, 1'b0);
                reg_data[REG_HIGH_LIMIT] = float_limit(1, 138, 144, 1'b0);
                reg_data[REG_LOW_LIMIT]  = float_limit(2, 138, 144, 1'b1);
                reg_data[REG_LOLO_LIMIT] = float_limit(3, 146, 152, 1'b1);
                reg_data[REG_SEVERITY_SET] = CFG_DATA_W'({2'($urandom_range(3, 1)),
                                                          2'($urandom_range(3, 1)),
                                                          2'($urandom_range(3, 1)),
                                                          2'($urandom_range(3, 1))});
            end
            CFG_SHUFFLED, CFG_DISABLED:
            begin
                reg_data[REG_HIHI_LIMIT] = float_limit(0, UNITY_EXP, 157, 1'($urandom));
                reg_data[REG_HIGH_LIMIT] = float_limit(1, UNITY_EXP, 157, 1'($urandom));
                reg_data[REG_LOW_LIMIT]  = float_limit(2, UNITY_EXP, 157, 1'($urandom));
                reg_data[REG_LOLO_LIMIT] = float_limit(3, UNITY_EXP, 157, 1'($urandom));
                reg_data[REG_SEVERITY_SET] = (kind == CFG_DISABLED)
                                             ? '0 : CFG_DATA_W'($urandom_range(255));
            end
            default:
            begin
                // rails; aim items at the saturation edges and around +/-1.0
                reg_data[REG_HIHI_LIMIT]   = 48'h7FFF_FFFF_FFFF;
                reg_data[REG_HIGH_LIMIT]   = 48'h8000_0000_0000;
                reg_data[REG_LOW_LIMIT]    = 48'h7FFF_FFFF_FFFF;
                reg_data[REG_LOLO_LIMIT]   = 48'h8000_0000_0000;
                reg_data[REG_SEVERITY_SET] = CFG_DATA_W'(8'hFF);
                near_bits[0] = 32'h4EFF_FFFF;
                near_bits[1] = 32'hCF00_0000;
                near_bits[2] = 32'h3F80_0000;
                near_bits[3] = 32'hBF80_0000;
            end
        endcase

        case (kind)
            CFG_EXTREME:
            begin
                // top bit of the band registers is beyond their width
                reg_data[REG_HYSTERESIS]       = 48'hFFFF_FFFF_FFFF;
                reg_data[REG_VALUE_DEADBAND]   = '0;
                reg_data[REG_ARCHIVE_DEADBAND] = '0;
            end
            CFG_DISABLED:
            begin
                reg_data[REG_HYSTERESIS]       = '0;
                reg_data[REG_VALUE_DEADBAND]   = 48'hFFFF_FFFF_FFFF;
                reg_data[REG_ARCHIVE_DEADBAND] = 48'h7FFF_FFFF_FFFF;
            end
            default:
            begin
                reg_data[REG_HYSTERESIS]       = random_word48() >> $urandom_range(47, 14);
                reg_data[REG_VALUE_DEADBAND]   = random_word48() >> $urandom_range(47, 20);
                reg_data[REG_ARCHIVE_DEADBAND] = random_word48() >> $urandom_range(47, 16);
            end
        endcase
    endtask

    // One write transaction per register, back to back; valid is dropped
    // only after the last one so it never toggles inside a time step.
    task automatic program_registers();
        reg_index_t idx;
        idx = REG_HIHI_LIMIT;
        do
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_data[idx];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            idx = idx.next();
        end
        while (idx != REG_HIHI_LIMIT);
        cfg_valid <= 1'b0;
    endtask

    // Random float pattern. Mix: raw 32-bit noise, repeats and one-word
    // changes, walks around a limit in the monotone {exp,mantissa} code,
    // and values spread over the range where the limits live.
    function automatic logic [31:0] next_float_bits();
        logic [31:0] bits;
        int          pick;
        int          span;
        int          code;
        pick = $urandom_range(99);
        if (pick < 10)
            bits = $urandom;
        else if (pick < 14)
            bits = prev_bits;
        else if (pick < 20)
            bits = $urandom_range(1) ? {prev_bits[31:16], 16'($urandom)}
                                     : {16'($urandom), prev_bits[15:0]};
        else if (pick < 60)
        begin
            if ($urandom_range(9) == 0)
                focus_slot = $urandom_range(LIMIT_COUNT - 1);
            case ($urandom_range(2))
                0:       span = 8;
                1:       span = 512;
                default: span = 1 << 17;
            endcase
            code = int'(near_bits[focus_slot][30:0]) + int'($urandom_range(2 * span)) - span;
            bits = {near_bits[focus_slot][31], 31'(code)};
        end
        else
            bits = {1'($urandom), 8'($urandom_range(160, 110)), 23'($urandom)};
        prev_bits = bits;
        return bits;
    endfunction

    // Offer one input transaction, with random idle cycles ahead of it,
    // and hold it until the block takes it.
    task automatic send_float(logic [31:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        word_high <= bits[31:16];
        word_low  <= bits[15:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    // The checker's count is registered, hence the edge before the loop.
    task automatic wait_until_settled();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = LIGHT_IDLE_PCT;
        recv_idle_pct = HEAVY_IDLE_PCT;

        // directed setting: hihi 2^30, high 2^20, low -2^20, lolo -2^30
        // (fixed point), hysteresis 0.25, deadbands 1.0 and 256.0
        reg_data[REG_HIHI_LIMIT]       = 48'h0000_4000_0000;
        reg_data[REG_HIGH_LIMIT]       = 48'h0000_0010_0000;
        reg_data[REG_LOW_LIMIT]        = 48'hFFFF_FFF0_0000;
        reg_data[REG_LOLO_LIMIT]       = 48'hFFFF_C000_0000;
        reg_data[REG_HYSTERESIS]       = 48'h0000_0000_4000;
        reg_data[REG_VALUE_DEADBAND]   = 48'h0000_0001_0000;
        reg_data[REG_ARCHIVE_DEADBAND] = 48'h0000_0100_0000;
        reg_data[REG_SEVERITY_SET]     = CFG_DATA_W'(8'hA5);
        program_registers();
        foreach (DIRECTED_FLOATS[i])
            send_float(DIRECTED_FLOATS[i]);

        // random chunks: sender light / receiver heavy, then swapped, then
        // no idling; each chunk starts from a drained pipe with new registers
        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++)
        begin
            wait_until_settled();
            if (chunk < 3)
            begin
                send_idle_pct = LIGHT_IDLE_PCT;
                recv_idle_pct = HEAVY_IDLE_PCT;
            end
            else if (chunk < 6)
            begin
                send_idle_pct = HEAVY_IDLE_PCT;
                recv_idle_pct = LIGHT_IDLE_PCT;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            make_config(CHUNK_KIND[chunk]);
            program_registers();
            repeat (CHUNK_ITEMS)
                send_float(next_float_bits());
        end

        wait_until_settled();
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
